// ----- rtl/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the biquad filter core: register indexes,
// multiplier operand selects and the controller to datapath command word.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int PART_BITS    = 56;
    localparam int NUM_COEFS    = 5;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    typedef enum logic [2:0] {
        MUL_X_B0 = 3'd0,
        MUL_X_B1 = 3'd1,
        MUL_X_B2 = 3'd2,
        MUL_Y_A1 = 3'd3,
        MUL_Y_A2 = 3'd4
    } t_mul_sel;

    typedef struct packed {
        logic     load_x;
        t_mul_sel mul_sel;
        logic     acc_a_fp;
        logic     acc_a_sp;
        logic     acc_b_load;
        logic     y_load;
        logic     fp_upd;
        logic     sp_upd;
        logic     out_load;
    } t_dp_cmd;

endpackage

// ----- rtl/biq_in_if.sv -----
// ----------------------------------------------------------------------------
// biq_in_if
// Input sample channel: valid/ready handshake carrying one audio sample.
// ----------------------------------------------------------------------------
interface biq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/biq_out_if.sv -----
// ----------------------------------------------------------------------------
// biq_out_if
// Result channel: valid/ready handshake carrying the filtered sample and flag.
// ----------------------------------------------------------------------------
interface biq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- rtl/biquad_iir_filter_core.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Second-order IIR filter, transposed direct form II, with programmable
// Q4.28 coefficients, rounded and saturated output and a clip flag.
// ----------------------------------------------------------------------------
// One sample is processed at a time: the next sample is taken only after
// the result of the last one has been handed to the output register, and
// that hand-off waits while the output register still holds a result that
// has not been taken. The pace is set by the single shared multiplier, which
// forms the five coefficient products one after another. A result waiting in
// the output register does not stop the next sample being taken.
// Coefficients reset to pass-through (b0 = 1.0, others zero) and should be
// written only while no sample is in flight.
module biquad_iir_filter_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_BITS      = 32,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    biq_in_if.sink                           i_smp,
    biq_out_if.source                        o_res,
    input  logic                             i_cfg_wr_en,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]             i_cfg_data
);

    biq_pkg::t_dp_cmd cmd;

    biq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    biq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_smp.sample_in),
        .o_sample    (o_res.sample_out),
        .o_clipped   (o_res.clipped)
    );

endmodule

// ----- rtl/biq_datapath.sv -----
// ----------------------------------------------------------------------------
// biq_datapath
// Coefficient registers, shared multiplier, accumulators, rounding and
// saturation, partial-sum state and the result register.
// ----------------------------------------------------------------------------
module biq_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_BITS      = 32,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  biq_pkg::t_dp_cmd                  i_cmd,
    input  logic                              i_cfg_wr_en,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COEF_BITS-1:0]              i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    output logic signed [SAMPLE_BITS-1:0]     o_sample,
    output logic                              o_clipped
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int PART_W = biq_pkg::PART_BITS;
    localparam int WIDE_W = (PROD_W > PART_W) ? PROD_W : PART_W;
    localparam int ACC_W  = WIDE_W + 2;

    localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] Y_MAX =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] P_MAX =
        {{(ACC_W + 1 - PART_W){1'b0}}, {(PART_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] P_MIN = ~P_MAX;
    localparam logic [COEF_BITS-1:0] B0_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic signed [COEF_BITS-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [PART_W-1:0]      r_fp, r_sp;
    logic signed [SAMPLE_BITS-1:0] r_x, r_y, r_out_y;
    logic                          r_clip, r_out_clip;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc_a, r_acc_b;

    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [COEF_BITS-1:0]   op_b;
    logic signed [ACC_W-1:0]       prod_ext, add_rhs, sub_lhs, sub_res;
    logic signed [ACC_W:0]         y_sum, y_wide;
    logic                          y_hi, y_lo;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [PART_W-1:0]      part_sat;

    // operand select for the shared multiplier
    always_comb begin
        op_a = r_x;
        op_b = r_b0;
        case (i_cmd.mul_sel)
            biq_pkg::MUL_X_B0: begin
                op_a = r_x;
                op_b = r_b0;
            end
            biq_pkg::MUL_X_B1: begin
                op_a = r_x;
                op_b = r_b1;
            end
            biq_pkg::MUL_X_B2: begin
                op_a = r_x;
                op_b = r_b2;
            end
            biq_pkg::MUL_Y_A1: begin
                op_a = r_y;
                op_b = r_a1;
            end
            biq_pkg::MUL_Y_A2: begin
                op_a = r_y;
                op_b = r_a2;
            end
            default: begin
                op_a = r_x;
                op_b = r_b0;
            end
        endcase
    end

    assign prod_ext = ACC_W'(r_prod);
    assign add_rhs  = i_cmd.acc_a_fp ? ACC_W'(r_fp) : ACC_W'(r_sp);
    assign sub_lhs  = i_cmd.fp_upd ? r_acc_a : r_acc_b;
    assign sub_res  = sub_lhs - prod_ext;

    // round half up, then clamp to the sample range
    assign y_sum  = (ACC_W + 1)'(r_acc_a) + ROUND_HALF;
    assign y_wide = y_sum >>> COEF_FRAC_BITS;
    assign y_hi   = y_wide > Y_MAX;
    assign y_lo   = y_wide < Y_MIN;

    always_comb begin
        if (y_hi) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (y_lo) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_wide[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        if (sub_res > P_MAX) begin
            part_sat = P_MAX[PART_W-1:0];
        end else if (sub_res < P_MIN) begin
            part_sat = P_MIN[PART_W-1:0];
        end else begin
            part_sat = sub_res[PART_W-1:0];
        end
    end

    // coefficients and partial sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_fp <= '0;
            r_sp <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (biq_pkg::t_coef_idx'(i_cfg_index))
                    biq_pkg::COEF_B0: r_b0 <= i_cfg_data;
                    biq_pkg::COEF_B1: r_b1 <= i_cfg_data;
                    biq_pkg::COEF_B2: r_b2 <= i_cfg_data;
                    biq_pkg::COEF_A1: r_a1 <= i_cfg_data;
                    biq_pkg::COEF_A2: r_a2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.fp_upd) begin
                r_fp <= part_sat;
            end
            if (i_cmd.sp_upd) begin
                r_sp <= part_sat;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample;
        end
        r_prod <= op_a * op_b;
        if (i_cmd.acc_a_fp || i_cmd.acc_a_sp) begin
            r_acc_a <= prod_ext + add_rhs;
        end
        if (i_cmd.acc_b_load) begin
            r_acc_b <= prod_ext;
        end
        if (i_cmd.y_load) begin
            r_y    <= y_sat;
            r_clip <= y_hi || y_lo;
        end
        if (i_cmd.out_load) begin
            r_out_y    <= r_y;
            r_out_clip <= r_clip;
        end
    end

    assign o_sample  = r_out_y;
    assign o_clipped = r_out_clip;

endmodule

// ----- rtl/biq_ctrl.sv -----
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer for one sample: accept, five multiplies, state update and the
// hand-off into the result register.
// ----------------------------------------------------------------------------
module biq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output biq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MB0  = 8'b0000_0010,
        S_MB1  = 8'b0000_0100,
        S_MB2  = 8'b0000_1000,
        S_MA1  = 8'b0001_0000,
        S_MA2  = 8'b0010_0000,
        S_SP   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.mul_sel    = biq_pkg::MUL_X_B0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_x = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MB0;
                end
            end
            S_MB0: begin
                o_cmd.mul_sel = biq_pkg::MUL_X_B0;
                n_state       = S_MB1;
            end
            S_MB1: begin
                o_cmd.mul_sel  = biq_pkg::MUL_X_B1;
                o_cmd.acc_a_fp = 1'b1;
                n_state        = S_MB2;
            end
            S_MB2: begin
                o_cmd.mul_sel  = biq_pkg::MUL_X_B2;
                o_cmd.y_load   = 1'b1;
                o_cmd.acc_a_sp = 1'b1;
                n_state        = S_MA1;
            end
            S_MA1: begin
                o_cmd.mul_sel    = biq_pkg::MUL_Y_A1;
                o_cmd.acc_b_load = 1'b1;
                n_state          = S_MA2;
            end
            S_MA2: begin
                o_cmd.mul_sel = biq_pkg::MUL_Y_A2;
                o_cmd.fp_upd  = 1'b1;
                n_state       = S_SP;
            end
            S_SP: begin
                o_cmd.sp_upd   = 1'b1;
                o_cmd.out_load = out_free;
                n_state        = out_free ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/biq_checker.sv -----
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks for the biquad filter core, bound to the top level.
// ----------------------------------------------------------------------------
module biq_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_sample_out,
    input logic                   i_clipped
);

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
    else $error("sample taken while another is in flight");

    // a result only appears while a sample is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
    else $error("result beat without a sample in flight");

    // clip flag only on a full-scale output
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_clipped) |-> (i_sample_out == S_MAX || i_sample_out == S_MIN))
    else $error("clip flag on a sample that is not full scale");

    // a waiting result beat holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_sample_out) && $stable(i_clipped)))
    else $error("result beat changed before it was taken");

endmodule

bind biquad_iir_filter_core biq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_biq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_sample_out (o_res.sample_out),
    .i_clipped    (o_res.clipped)
);

// ----- bench/tb_biquad_iir_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_biquad_iir_filter_core
// Self-checking bench for the biquad core. A scoreboard carries its own copy
// of the coefficients and both partial sums, predicts every filtered sample
// and its clip flag, and checks each output beat in order. A directed part
// covers the sample extremes, pass-through after reset, rounding ties, output
// saturation and writes to unused register indexes.
// Random phases then run mild, full-range and extreme coefficient sets with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter_core;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int HOLD_CYCLES    = 400;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COEF_BITS-1:0]          t_coef;
    typedef t_coef                         t_coef_set [biq_pkg::NUM_COEFS];

    typedef struct {
        t_sample smp;
        logic    clip;
    } t_filtered;

    localparam t_sample SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_coef   COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam t_coef   COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam t_coef   COEF_HALF = t_coef'(1) << (COEF_FRAC_BITS - 1);

    class biquad_scoreboard;
        longint    coef [biq_pkg::NUM_COEFS];
        longint    first_part;
        longint    second_part;
        t_filtered expected_q [$];
        int        errors;

        function void reset_state();
            foreach (coef[i]) coef[i] = 0;
            coef[biq_pkg::COEF_B0] = longint'(1) << COEF_FRAC_BITS;
            first_part  = 0;
            second_part = 0;
            errors      = 0;
            expected_q.delete();
        endfunction

        function void set_coef(logic [biq_pkg::CFG_IDX_BITS-1:0] idx, t_coef val);
            logic signed [COEF_BITS-1:0] s;
            s = val;
            if (idx < biq_pkg::NUM_COEFS)
                coef[idx] = s;
        endfunction

        function longint sat_part(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (biq_pkg::PART_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void note_sample(t_sample s);
            longint    x;
            longint    acc;
            longint    y;
            longint    hi;
            longint    lo;
            longint    p1;
            longint    p2;
            t_filtered r;
            hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            x = s;
            acc = x * coef[biq_pkg::COEF_B0] + first_part;
            // round half up, then saturate
            y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            r.clip = 1'b0;
            if (y > hi) begin
                y = hi;
                r.clip = 1'b1;
            end else if (y < lo) begin
                y = lo;
                r.clip = 1'b1;
            end
            p1 = x * coef[biq_pkg::COEF_B1] + second_part - coef[biq_pkg::COEF_A1] * y;
            p2 = x * coef[biq_pkg::COEF_B2] - coef[biq_pkg::COEF_A2] * y;
            first_part  = sat_part(p1);
            second_part = sat_part(p2);
            r.smp = t_sample'(y);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_sample s, logic c);
            t_filtered e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: output beat %0d with no sample pending", $time, s);
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.smp) begin
                errors++;
                $display("%0t: sample_out expected %0d actual %0d", $time, e.smp, s);
            end
            if (c !== e.clip) begin
                errors++;
                $display("%0t: clipped expected %0b actual %0b", $time, e.clip, c);
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [biq_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [COEF_BITS-1:0]             i_cfg_data;

    biq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    biq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_if ();

    biquad_scoreboard sb;
    bit               in_idle_on;
    bit               out_idle_on;
    bit               hold_out_req;

    biquad_iir_filter_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .o_res       (res_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("tb_biquad_iir_filter_core: errors");
        $finish;
    end

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_coef_set mild_coefs();
        t_coef_set c;
        foreach (c[i]) c[i] = t_coef'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
        c[biq_pkg::COEF_A2] = t_coef'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
        return c;
    endfunction

    function automatic t_coef_set wide_coefs();
        t_coef_set c;
        foreach (c[i]) c[i] = t_coef'($urandom);
        return c;
    endfunction

    // input beat, valid held across back-to-back beats
    task automatic send_sample(input t_sample s);
        int gap;
        gap = draw_gap(in_idle_on);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.sample_in <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(s);
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic program_coefs(input t_coef_set c, input bit poke_unused);
        t_coef junk;
        for (int i = 0; i < biq_pkg::NUM_COEFS; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= biq_pkg::CFG_IDX_BITS'(i);
            i_cfg_data  <= c[i];
            sb.set_coef(biq_pkg::CFG_IDX_BITS'(i), c[i]);
            @(posedge i_clk);
        end
        // unused indexes must leave the coefficients alone
        if (poke_unused) begin
            for (int i = biq_pkg::NUM_COEFS; i < (1 << biq_pkg::CFG_IDX_BITS); i++) begin
                junk = t_coef'($urandom);
                i_cfg_wr_en <= 1'b1;
                i_cfg_index <= biq_pkg::CFG_IDX_BITS'(i);
                i_cfg_data  <= junk;
                sb.set_coef(biq_pkg::CFG_IDX_BITS'(i), junk);
                @(posedge i_clk);
            end
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input t_coef_set c, input int n, input bit in_idle,
                             input bit out_idle, input bit hold);
        program_coefs(c, 1'b1);
        in_idle_on   = in_idle;
        out_idle_on  = out_idle;
        hold_out_req = hold;
        for (int k = 0; k < n; k++)
            send_sample(random_sample());
        drain();
    endtask

    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(out_idle_on);
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            sb.check_result(res_if.sample_out, res_if.clipped);
        end
    end

    initial begin : stimulus
        t_coef_set cs;
        sb = new;
        sb.reset_state();
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        smp_if.valid     = 1'b0;
        smp_if.sample_in = '0;
        in_idle_on       = 1'b1;
        out_idle_on      = 1'b1;
        hold_out_req     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through straight after reset
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(t_sample'(0));
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));
        drain();

        // half gain, rounding ties
        cs = '{default: '0};
        cs[biq_pkg::COEF_B0] = COEF_HALF;
        program_coefs(cs, 1'b1);
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));
        send_sample(t_sample'(3));
        send_sample(t_sample'(-3));
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        drain();

        // near eight times gain, output saturates both ways
        cs[biq_pkg::COEF_B0] = COEF_MAX;
        program_coefs(cs, 1'b0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(t_sample'(1));
        send_sample(t_sample'(-1));
        send_sample(t_sample'(1 << 20));
        drain();

        // extreme feedback with full-scale coefficients
        cs = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX};
        program_coefs(cs, 1'b0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        drain();

        run_phase(mild_coefs(), 400, 1'b1, 1'b1, 1'b0);
        run_phase(wide_coefs(), 300, 1'b0, 1'b1, 1'b1);
        cs = '{default: COEF_MAX};
        run_phase(cs, 100, 1'b0, 1'b0, 1'b0);
        cs = '{default: COEF_MIN};
        run_phase(cs, 100, 1'b1, 1'b0, 1'b0);
        cs = '{default: '0};
        run_phase(cs, 50, 1'b0, 1'b1, 1'b0);
        run_phase(mild_coefs(), 300, 1'b0, 1'b1, 1'b0);
        run_phase(wide_coefs(), 300, 1'b1, 1'b1, 1'b0);

        if (sb.errors == 0)
            $display("tb_biquad_iir_filter_core: clean");
        else
            $display("tb_biquad_iir_filter_core: errors");
        $finish;
    end

endmodule
